// ----- rtl/orbs_pkg.sv -----
// Package for the overwriting ring buffer with statistics.
// Holds command codes, the controller state type and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package orbs_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_SNAP  = 3'd3,
    KIND_CLEAR = 3'd4,
    KIND_RSTAT = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_DONE,
    ST_WALK,
    ST_WALK_END,
    ST_DIV,
    ST_VAR_MUL,
    ST_VAR_SUB,
    ST_SQRT,
    ST_SQRT_CMP,
    ST_SNAP_DONE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_write;
    logic do_read_issue;
    logic do_peek_issue;
    logic do_read_done;
    logic do_peek_done;
    logic do_clear;
    logic do_rstat;
    logic walk_start;
    logic walk_step;
    logic div_start;
    logic div_step;
    logic var_mul;
    logic var_sub;
    logic sqrt_start;
    logic sqrt_mul;
    logic sqrt_cmp;
    logic snap_done;
    logic emit_plain;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic walk_last;
    logic div_last;
    logic sqrt_last;
    logic mul_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/orbs_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module orbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write: a read of the written address returns the old data; read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/orbs_ctrl.sv -----
// Controller state machine for the ring buffer.
// Depends on orbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module orbs_ctrl
  import orbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] kind,
  input  stat_t           st,
  output logic            busy,
  output ctrl_t           ctl
);
  state_t state, state_next;
  logic [2:0] kind_q;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (kind)
            KIND_WRITE: begin
              ctl.do_write = 1'b1;
              state_next = ST_EMIT;
            end
            KIND_READ: begin
              if (st.empty) begin
                ctl.emit_plain = 1'b1;
                state_next = ST_EMIT;
              end else begin
                ctl.do_read_issue = 1'b1;
                state_next = ST_RD_WAIT;
              end
            end
            KIND_PEEK: begin
              if (st.empty) begin
                ctl.emit_plain = 1'b1;
                state_next = ST_EMIT;
              end else begin
                ctl.do_peek_issue = 1'b1;
                state_next = ST_RD_WAIT;
              end
            end
            KIND_SNAP: begin
              if (st.empty) begin
                ctl.emit_plain = 1'b1;
                state_next = ST_EMIT;
              end else begin
                ctl.walk_start = 1'b1;
                state_next = ST_WALK;
              end
            end
            KIND_CLEAR: begin
              ctl.do_clear = 1'b1;
              state_next = ST_EMIT;
            end
            KIND_RSTAT: begin
              ctl.do_rstat = 1'b1;
              state_next = ST_EMIT;
            end
            default: begin
              ctl.emit_plain = 1'b1;
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_RD_DONE;
      ST_RD_DONE: begin
        state_next = ST_IDLE;
      end
      ST_WALK: begin
        ctl.walk_step = 1'b1;
        if (st.walk_last) begin
          state_next = ST_WALK_END;
        end
      end
      ST_WALK_END: begin
        ctl.walk_step = 1'b1;
        ctl.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_VAR_MUL;
        end
      end
      ST_VAR_MUL: begin
        ctl.var_mul = 1'b1;
        if (st.mul_last) begin
          state_next = ST_VAR_SUB;
        end
      end
      ST_VAR_SUB: begin
        ctl.var_sub = 1'b1;
        ctl.sqrt_start = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        ctl.sqrt_mul = 1'b1;
        if (st.mul_last) begin
          state_next = ST_SQRT_CMP;
        end
      end
      ST_SQRT_CMP: begin
        ctl.sqrt_cmp = 1'b1;
        state_next = st.sqrt_last ? ST_SNAP_DONE : ST_SQRT;
      end
      ST_SNAP_DONE: begin
        ctl.snap_done = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    // RAM data for a read or peek is valid in the cycle after the issue.
    if (state == ST_RD_WAIT) begin
      ctl.do_read_done = (kind_q == KIND_READ);
      ctl.do_peek_done = (kind_q == KIND_PEEK);
    end
  end

  // Remember the kind of a pending read or peek.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind_q <= kind;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/orbs_dp.sv -----
// Datapath for the ring buffer: pointers, counters, sample RAM and the
// statistics units (walk accumulator, serial divider, shared multiplier, root).
// Depends on orbs_pkg and orbs_ram.
`timescale 1ns / 1ps
`default_nettype none
module orbs_dp
  import orbs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [23:0] sample_in,
  input  ctrl_t                   ctl,
  output stat_t                   st,
  output logic                    done,
  output logic                    ok,
  output logic signed [23:0]      value,
  output logic signed [23:0]      min_value,
  output logic signed [23:0]      max_value,
  output logic [23:0]             deviation,
  output logic [10:0]             fill_count,
  output logic                    overwrote,
  output logic [31:0]             writes_total,
  output logic [31:0]             reads_total,
  output logic [31:0]             overwrites_total,
  output logic [10:0]             peak_fill
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [10:0] DEPTH_C = 11'(DEPTH);
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  logic [AW-1:0] wpos, rpos, walk_pos, ram_addr;
  logic [10:0]   count, peak, walk_left;
  logic [31:0]   wcnt, rcnt, ocnt;
  logic          ram_we;
  logic [23:0]   ram_rdata;
  logic          walk_first;

  function automatic logic [AW-1:0] inc_pos(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // Sample store address selection.
  always_comb begin
    ram_we = ctl.do_write;
    if (ctl.do_write) begin
      ram_addr = wpos;
    end else if (ctl.do_read_issue || ctl.walk_start) begin
      ram_addr = rpos;
    end else if (ctl.do_peek_issue) begin
      ram_addr = (wpos == '0) ? LAST : wpos - 1'b1;
    end else begin
      ram_addr = walk_pos;
    end
  end

  orbs_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_in),
    .rdata (ram_rdata)
  );

  // Pointers, fill and statistics counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos  <= '0;
      rpos  <= '0;
      count <= '0;
      peak  <= '0;
      wcnt  <= '0;
      rcnt  <= '0;
      ocnt  <= '0;
    end else begin
      if (ctl.do_write) begin
        wpos <= inc_pos(wpos);
        if (wcnt != CNT_MAX) wcnt <= wcnt + 1'b1;
        if (count >= DEPTH_C) begin
          rpos <= inc_pos(rpos);
          if (ocnt != CNT_MAX) ocnt <= ocnt + 1'b1;
        end else begin
          count <= count + 1'b1;
          if (count + 11'd1 > peak) peak <= count + 11'd1;
        end
        if (count >= DEPTH_C && count > peak) peak <= count;
      end
      if (ctl.do_read_issue) begin
        rpos  <= inc_pos(rpos);
        count <= count - 1'b1;
        if (rcnt != CNT_MAX) rcnt <= rcnt + 1'b1;
      end
      if (ctl.do_clear) begin
        wpos  <= '0;
        rpos  <= '0;
        count <= '0;
      end
      if (ctl.do_rstat) begin
        wcnt <= '0;
        rcnt <= '0;
        ocnt <= '0;
        peak <= '0;
      end
    end
  end

  // Walk over the stored samples, oldest first; RAM read data is registered.
  logic signed [34:0] s1;
  logic [57:0]        s2;
  logic signed [23:0] lo, hi;
  logic signed [47:0] sq;
  logic               sq_valid;
  logic [10:0]        take_left;
  logic               sample_take;
  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      walk_pos   <= inc_pos(rpos);
      walk_left  <= count - 1'b1;
      walk_first <= 1'b1;
      s1 <= '0;
      s2 <= '0;
      sq_valid <= 1'b0;
    end else if (ctl.walk_step) begin
      if (walk_left != '0) begin
        walk_pos  <= inc_pos(walk_pos);
        walk_left <= walk_left - 1'b1;
      end
    end
    // First data word appears the cycle after walk_start.
    if (ctl.walk_step || sq_valid) begin
      sq       <= $signed(ram_rdata) * $signed(ram_rdata);
      sq_valid <= ctl.walk_step && sample_take;
      if (ctl.walk_step && sample_take) begin
        s1 <= s1 + 35'($signed(ram_rdata));
        if (walk_first || $signed(ram_rdata) < lo) lo <= ram_rdata;
        if (walk_first || $signed(ram_rdata) > hi) hi <= ram_rdata;
        walk_first <= 1'b0;
      end
      if (sq_valid) s2 <= s2 + 58'(unsigned'(sq));
    end
  end

  // Walk starts reading at rpos in the walk_start cycle, so the first
  // step sees data for rpos; count steps take count samples.
  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      take_left <= count;
    end else if (ctl.walk_step && take_left != '0) begin
      take_left <= take_left - 1'b1;
    end
  end
  assign sample_take = (take_left != '0);
  assign st.walk_last = (take_left == 11'd1);

  // Serial restoring divider for the mean: |s1| / count, 35 steps.
  logic [34:0] quo, mag;
  logic [10:0] rem;
  logic [11:0] rem_sh;
  logic [5:0]  div_cnt;
  logic        s1_neg;
  assign rem_sh = {rem, quo[34]};
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      s1_neg  <= 1'b0;
      div_cnt <= '0;
    end
    if (ctl.div_step) begin
      if (div_cnt == 6'd0) begin
        s1_neg <= s1[34];
        mag    <= s1[34] ? 35'(-s1) : 35'(s1);
        quo    <= s1[34] ? 35'(-s1) : 35'(s1);
        rem    <= '0;
      end else begin
        if (rem_sh >= {1'b0, count}) begin
          rem <= 11'(rem_sh - {1'b0, count});
          quo <= {quo[33:0], 1'b1};
        end else begin
          rem <= rem_sh[10:0];
          quo <= {quo[33:0], 1'b0};
        end
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end
  assign st.div_last = (div_cnt == 6'd35);

  // Shared multiplier: 64 x 64 product built from 32 x 32 partial products.
  // Each product loads its operands and then accumulates its partial products one after another.
  logic [63:0]  ma, mb;
  logic [127:0] macc;
  logic [1:0]   mcnt;
  logic         mul_run;
  logic [63:0]  pp;
  logic [31:0]  ma_h, mb_h;
  logic [127:0] pp_sh;
  logic [127:0] nx, first_prod;
  logic [23:0]  d, cand;
  logic [4:0]   bitn;
  logic [1:0]   phase;
  logic [34:0]  t_prod;
  logic [63:0]  t;
  always_comb begin
    ma_h = mcnt[1] ? ma[63:32] : ma[31:0];
    mb_h = mcnt[0] ? mb[63:32] : mb[31:0];
  end
  always_comb begin
    pp    = ma_h * mb_h;
    pp_sh = 128'(pp) << ({1'b0, mcnt[1], 5'd0} + {1'b0, mcnt[0], 5'd0});
  end
  // The first variance product does not end the multiply state.
  assign st.mul_last = mul_run && (mcnt == 2'd3) && (phase != 2'd0);

  // Partial product sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run <= 1'b0;
      mcnt    <= '0;
    end else if (ctl.var_mul || ctl.sqrt_mul) begin
      if (!mul_run) begin
        mul_run <= 1'b1;
        mcnt    <= '0;
      end else begin
        mul_run <= (mcnt != 2'd3);
        mcnt    <= mcnt + 1'b1;
      end
    end else begin
      mul_run <= 1'b0;
      mcnt    <= '0;
    end
  end

  // Operand loads, accumulation, variance numerator and root trials.
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      phase <= 2'd0;
    end
    if ((ctl.var_mul || ctl.sqrt_mul) && !mul_run) begin
      ma   <= ctl.sqrt_mul ? t : ((phase == 2'd0) ? 64'(count) : 64'(mag));
      mb   <= ctl.sqrt_mul ? t : ((phase == 2'd0) ? 64'(s2) : 64'(mag));
      macc <= '0;
    end
    if ((ctl.var_mul || ctl.sqrt_mul) && mul_run) begin
      macc <= macc + pp_sh;
    end
    if (ctl.var_mul && mul_run && mcnt == 2'd3 && phase == 2'd0) begin
      first_prod <= macc + pp_sh;
      phase      <= 2'd1;
    end
    if (ctl.var_sub) begin
      nx <= first_prod - (macc);
    end
    if (ctl.sqrt_start) begin
      d    <= '0;
      bitn <= 5'd23;
    end
    if (ctl.sqrt_cmp) begin
      if (macc <= nx) d <= cand;
      bitn <= bitn - 1'b1;
    end
  end
  assign cand   = d | (24'd1 << bitn);
  assign t_prod = cand * count;
  assign t      = 64'(t_prod);
  assign st.sqrt_last = (bitn == 5'd0);

  assign st.empty = (count == '0);

  // Result register: one strobe cycle per command.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.do_write | ctl.do_clear | ctl.do_rstat | ctl.emit_plain |
              ctl.do_read_done | ctl.do_peek_done | ctl.snap_done;
    end
    ok        <= ctl.do_read_done | ctl.do_peek_done;
    value     <= (ctl.do_read_done | ctl.do_peek_done) ? ram_rdata :
                 ctl.snap_done ? (s1_neg ? 24'(-quo) : quo[23:0]) : '0;
    min_value <= ctl.snap_done ? lo : '0;
    max_value <= ctl.snap_done ? hi : '0;
    deviation <= ctl.snap_done ? d : '0;
    overwrote <= ctl.do_write && count >= DEPTH_C;
  end
  assign fill_count       = count;
  assign writes_total     = wcnt;
  assign reads_total      = rcnt;
  assign overwrites_total = ocnt;
  assign peak_fill        = peak;
endmodule
`default_nettype wire

// ----- rtl/overwriting_ring_buffer_with_stats.sv -----
// Top level of the overwriting ring buffer with statistics.
// Depends on orbs_pkg, orbs_ctrl, orbs_dp and orbs_ram.
//
// Channel  | Signals                               | Beat taken when
// ---------+---------------------------------------+---------------------
// command  | start, busy, kind, sample             | start & !busy
// result   | done, ok, value, ... , peak_fill      | done (one cycle)
//
// Write, clear, statistics reset, spare codes and commands on an empty
// buffer pass through the emit state; read and peek pass through a wait
// and a done state (one RAM read with registered data). A snapshot walks
// the fill count through the single RAM port, runs a 35-step divider, then
// a shared 32x32 multiplier for two variance products and 24 root trials.
// Reset is synchronous; the results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module overwriting_ring_buffer_with_stats
  import orbs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         kind,
  input  wire logic signed [23:0] sample,
  output logic                    done,
  output logic                    ok,
  output logic signed [23:0]      value,
  output logic signed [23:0]      min_value,
  output logic signed [23:0]      max_value,
  output logic [23:0]             deviation,
  output logic [10:0]             fill_count,
  output logic                    overwrote,
  output logic [31:0]             writes_total,
  output logic [31:0]             reads_total,
  output logic [31:0]             overwrites_total,
  output logic [10:0]             peak_fill
);
  ctrl_t ctl;
  stat_t st;

  orbs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .kind (kind),
    .st   (st),
    .busy (busy),
    .ctl  (ctl)
  );

  orbs_dp #(.DEPTH(DEPTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .sample_in        (sample),
    .ctl              (ctl),
    .st               (st),
    .done             (done),
    .ok               (ok),
    .value            (value),
    .min_value        (min_value),
    .max_value        (max_value),
    .deviation        (deviation),
    .fill_count       (fill_count),
    .overwrote        (overwrote),
    .writes_total     (writes_total),
    .reads_total      (reads_total),
    .overwrites_total (overwrites_total),
    .peak_fill        (peak_fill)
  );
endmodule
`default_nettype wire

// ----- sim/orbs_checker.sv -----
// Scoreboard for the overwriting ring buffer with statistics.
// Predicts every result from accepted command beats and compares done beats; uses orbs_pkg.
`timescale 1ns / 1ps
module orbs_checker
  import orbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [23:0] sample,
  input  logic               done,
  input  logic               ok,
  input  logic signed [23:0] value,
  input  logic signed [23:0] min_value,
  input  logic signed [23:0] max_value,
  input  logic [23:0]        deviation,
  input  logic [10:0]        fill_count,
  input  logic               overwrote,
  input  logic [31:0]        writes_total,
  input  logic [31:0]        reads_total,
  input  logic [31:0]        overwrites_total,
  input  logic [10:0]        peak_fill,
  output int                 mismatches,
  output int                 pending
);

  localparam int SLOTS = 1024;
  localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               ok;
    logic signed [23:0] value;
    logic signed [23:0] min_value;
    logic signed [23:0] max_value;
    logic [23:0]        deviation;
    logic [10:0]        fill_count;
    logic               overwrote;
    logic [31:0]        writes_total;
    logic [31:0]        reads_total;
    logic [31:0]        overwrites_total;
    logic [10:0]        peak_fill;
  } buf_result_t;

  // Shadow copy of the buffer and its statistics.
  logic signed [23:0] shadow_mem [SLOTS];
  int                 head_pos, tail_pos, held;
  logic [31:0]        wr_cnt, rd_cnt, ovw_cnt;
  int                 peak_held;
  buf_result_t        awaited [$];

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == CNT_TOP) ? c : c + 32'd1;
  endfunction

  function automatic int step_pos(input int p);
    return (p + 1 >= SLOTS) ? 0 : p + 1;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("t=%0t %s: got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Apply one accepted command beat to the shadow state and queue its result.
  task automatic predict_beat(input logic [2:0] k, input logic signed [23:0] s);
    buf_result_t r;
    int p;
    logic signed [127:0] s1, s2, nn, x, c, t;
    logic signed [23:0] v, lo, hi;
    logic [23:0] d;
    r = '0;
    case (k)
      KIND_WRITE: begin
        shadow_mem[head_pos] = s;
        head_pos = step_pos(head_pos);
        if (held >= SLOTS) begin
          tail_pos = step_pos(tail_pos);
          ovw_cnt = bump(ovw_cnt);
          r.overwrote = 1'b1;
        end else begin
          held++;
        end
        wr_cnt = bump(wr_cnt);
        if (held > peak_held) peak_held = held;
      end
      KIND_READ: begin
        if (held != 0) begin
          r.value = shadow_mem[tail_pos];
          tail_pos = step_pos(tail_pos);
          held--;
          rd_cnt = bump(rd_cnt);
          r.ok = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (held != 0) begin
          r.value = shadow_mem[(head_pos == 0) ? SLOTS - 1 : head_pos - 1];
          r.ok = 1'b1;
        end
      end
      KIND_SNAP: begin
        if (held != 0) begin
          s1 = 0;
          s2 = 0;
          p = tail_pos;
          lo = shadow_mem[p];
          hi = lo;
          for (int i = 0; i < held; i++) begin
            v = shadow_mem[p];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
            s1 += 128'(v);
            s2 += 128'(v) * 128'(v);
            p = step_pos(p);
          end
          nn = held;
          r.value = 24'(s1 / nn);
          r.min_value = lo;
          r.max_value = hi;
          // n^2 times the variance, then the largest d with (d*n)^2 within it.
          x = nn * s2 - s1 * s1;
          d = '0;
          for (int b = 23; b >= 0; b--) begin
            c = 128'(d | (24'd1 << b));
            t = c * nn;
            if (t * t <= x) d = 24'(c);
          end
          r.deviation = d;
        end
      end
      KIND_CLEAR: begin
        head_pos = 0;
        tail_pos = 0;
        held = 0;
        for (int i = 0; i < SLOTS; i++) shadow_mem[i] = '0;
      end
      KIND_RSTAT: begin
        wr_cnt = '0;
        rd_cnt = '0;
        ovw_cnt = '0;
        peak_held = 0;
      end
      default: ;
    endcase
    r.fill_count = 11'(held);
    r.writes_total = wr_cnt;
    r.reads_total = rd_cnt;
    r.overwrites_total = ovw_cnt;
    r.peak_fill = 11'(peak_held);
    awaited.push_back(r);
  endtask

  // Compare one done beat against the oldest prediction.
  task automatic check_beat();
    buf_result_t e;
    if (awaited.size() == 0) begin
      $display("t=%0t result beat with nothing expected", $realtime);
      mismatches++;
      return;
    end
    e = awaited.pop_front();
    if (ok !== e.ok) report("ok", 32'(ok), 32'(e.ok));
    if (value !== e.value) report("value", 32'(value), 32'(e.value));
    if (min_value !== e.min_value) report("min_value", 32'(min_value), 32'(e.min_value));
    if (max_value !== e.max_value) report("max_value", 32'(max_value), 32'(e.max_value));
    if (deviation !== e.deviation) report("deviation", 32'(deviation), 32'(e.deviation));
    if (fill_count !== e.fill_count) report("fill_count", 32'(fill_count), 32'(e.fill_count));
    if (overwrote !== e.overwrote) report("overwrote", 32'(overwrote), 32'(e.overwrote));
    if (writes_total !== e.writes_total) report("writes_total", writes_total, e.writes_total);
    if (reads_total !== e.reads_total) report("reads_total", reads_total, e.reads_total);
    if (overwrites_total !== e.overwrites_total)
      report("overwrites_total", overwrites_total, e.overwrites_total);
    if (peak_fill !== e.peak_fill) report("peak_fill", 32'(peak_fill), 32'(e.peak_fill));
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    head_pos = 0;
    tail_pos = 0;
    held = 0;
    peak_held = 0;
    wr_cnt = '0;
    rd_cnt = '0;
    ovw_cnt = '0;
    for (int i = 0; i < SLOTS; i++) shadow_mem[i] = '0;
  end

  // Results are checked before the command taken at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_beat();
      if (start && !busy) predict_beat(kind, sample);
    end
    pending = awaited.size();
  end

endmodule

// ----- sim/overwriting_ring_buffer_with_stats_tb.sv -----
// Top of the testbench for the overwriting ring buffer with statistics.
// Drives command beats in bursts and gives the verdict; depends on orbs_pkg, orbs_checker and the DUT.
`timescale 1ns / 1ps
module overwriting_ring_buffer_with_stats_tb;
  import orbs_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [23:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h80_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         kind = '0;
  logic signed [23:0] sample = '0;
  logic               busy, done, ok, overwrote;
  logic signed [23:0] value, min_value, max_value;
  logic [23:0]        deviation;
  logic [10:0]        fill_count, peak_fill;
  logic [31:0]        writes_total, reads_total, overwrites_total;
  int                 mismatches, pending;
  int                 burst_left = 0;

  always #2 clk = ~clk;

  overwriting_ring_buffer_with_stats dut (.*);

  orbs_checker scoreboard (.*);

  // One command beat; start stays high unless a gap follows.
  task automatic send(input logic [2:0] k, input logic [23:0] s);
    int gap;
    start <= 1'b1;
    kind <= k;
    sample <= s;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(30, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(7, 1);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return 24'($signed(12'($urandom)));
      default: return 24'($urandom);
    endcase
  endfunction

  // Random command with weights given in percent.
  task automatic random_beat(input int w_write, input int w_read, input int w_peek,
                             input int w_snap);
    int r;
    r = $urandom_range(99);
    if (r < w_write) send(KIND_WRITE, pick_sample());
    else if (r < w_write + w_read) send(KIND_READ, 24'($urandom));
    else if (r < w_write + w_read + w_peek) send(KIND_PEEK, 24'($urandom));
    else if (r < w_write + w_read + w_peek + w_snap) send(KIND_SNAP, 24'($urandom));
    else case ($urandom_range(4))
      0: send(KIND_CLEAR, 24'($urandom));
      1, 2: send(KIND_RSTAT, 24'($urandom));
      3: send(KIND_SPARE_LO, 24'($urandom));
      default: send(KIND_SPARE_HI, 24'($urandom));
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, extremes, every command and the spare codes.
    send(KIND_RSTAT, '0);
    send(KIND_READ, '0);
    send(KIND_PEEK, '0);
    send(KIND_SNAP, '0);
    send(KIND_SPARE_LO, SAMPLE_MAX);
    send(KIND_SPARE_HI, SAMPLE_MIN);
    send(KIND_WRITE, SAMPLE_MAX);
    send(KIND_WRITE, SAMPLE_MIN);
    send(KIND_PEEK, '0);
    send(KIND_SNAP, '0);
    send(KIND_WRITE, 24'h00_0000);
    send(KIND_WRITE, 24'hFF_FFFF);
    send(KIND_SNAP, '0);
    send(KIND_READ, '0);
    send(KIND_READ, '0);
    send(KIND_READ, '0);
    send(KIND_READ, '0);
    send(KIND_READ, '0);
    send(KIND_WRITE, 24'h00_0100);
    send(KIND_WRITE, 24'hFF_FF00);
    send(KIND_WRITE, 24'h00_0300);
    send(KIND_SNAP, '0);
    send(KIND_CLEAR, '0);
    send(KIND_SNAP, '0);
    send(KIND_RSTAT, SAMPLE_MAX);

    // Mixed traffic at low fill, where snapshots are cheap.
    repeat (700) random_beat(40, 28, 14, 10);

    // Hold off until the buffer has answered everything.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);

    // Mostly writes, so the fill climbs toward the depth, with sparse snapshots.
    repeat (1250) random_beat(88, 5, 4, 1);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
